// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define QEC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition implies a property at the next clock edge
`define QEC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hw/rtl/qec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qec_pkg
// shared widths, pipeline record types and helper functions for the
// quaternion to euler and curvature pipeline
// ----------------------------------------------------------------------------
package qec_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANG_LEN           = 32;

    localparam int VW        = 37;   // cordic x/y width
    localparam int ZW        = 34;   // cordic angle width, 2^31 = pi
    localparam int SW        = 30;   // clamped pitch argument
    localparam int SQ_STEPS  = 29;
    localparam int NW        = 2 * SQ_STEPS;
    localparam int RW        = 32;
    localparam int RTW       = SQ_STEPS;
    localparam int DIV_STEPS = 28;
    localparam int DW        = DIV_STEPS;
    localparam int DSW       = 16;
    localparam int AW        = 16;   // output angle width
    localparam int CW        = 24;   // curvature width

    localparam logic signed [ZW-1:0] ZPI = 34'sd2147483648;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zf;
    } cvec_t;

    typedef struct packed {
        logic [NW-1:0]        n;
        logic [RW-1:0]        rem;
        logic [RTW-1:0]       root;
        logic signed [SW-1:0] s;
    } sqrt_t;

    typedef struct packed {
        logic [DW-1:0]  dvd;
        logic [DSW-1:0] rem;
        logic [DW-1:0]  quo;
        logic [DSW-1:0] dsr;
        logic           neg;
        logic           zf;
    } div_t;

    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] r;
        begin
            unique case (i)
                0:  r = 34'sd536870912;
                1:  r = 34'sd316933406;
                2:  r = 34'sd167458907;
                3:  r = 34'sd85004756;
                4:  r = 34'sd42667331;
                5:  r = 34'sd21354465;
                6:  r = 34'sd10680862;
                7:  r = 34'sd5340245;
                8:  r = 34'sd2670163;
                9:  r = 34'sd1335087;
                10: r = 34'sd667544;
                11: r = 34'sd333772;
                12: r = 34'sd166886;
                13: r = 34'sd83443;
                14: r = 34'sd41722;
                15: r = 34'sd20861;
                16: r = 34'sd10430;
                17: r = 34'sd5215;
                18: r = 34'sd2608;
                19: r = 34'sd1304;
                20: r = 34'sd652;
                21: r = 34'sd326;
                22: r = 34'sd163;
                23: r = 34'sd81;
                24: r = 34'sd41;
                25: r = 34'sd20;
                26: r = 34'sd10;
                27: r = 34'sd5;
                28: r = 34'sd3;
                29: r = 34'sd1;
                30: r = 34'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // fold left half plane into right half plane, start angle +-pi
    function automatic cvec_t cordic_pre(input logic signed [VW-1:0] ny,
                                         input logic signed [VW-1:0] dx);
        cvec_t v;
        begin
            v.zf = (ny == '0) && (dx == '0);
            v.x  = dx;
            v.y  = ny;
            v.z  = '0;
            if (dx < 0)
            begin
                v.x = -dx;
                v.y = -ny;
                v.z = (ny >= 0) ? ZPI : -ZPI;
            end
            return v;
        end
    endfunction

    // round to 16-bit fraction of pi with saturation
    function automatic logic signed [AW-1:0] angle_out(input logic signed [ZW-1:0] a,
                                                       input logic zf);
        logic signed [ZW:0]    t;
        logic signed [ZW-16:0] r;
        logic signed [AW-1:0]  o;
        begin
            t = (ZW+1)'(a) + (ZW+1)'(32768);
            r = t[ZW:16];
            if (zf)
                o = '0;
            else if (r > (ZW-15)'(32767))
                o = 16'sd32767;
            else if (r < -(ZW-15)'(32768))
                o = -16'sd32768;
            else
                o = AW'(r);
            return o;
        end
    endfunction

endpackage

// File: hw/rtl/quaternion_euler_curvature.sv
`timescale 1ns / 1ps
// the pitch lane is the longest path from transaction in to result out
// (29 square root cells followed by the cordic cells)
// throughput: one transaction per cycle unless stalled, every cell takes a new transaction
// the whole chain holds while a result waits under out_stall
// reset clears only the valid bits; no clearing pass
// ----------------------------------------------------------------------------
// quaternion_euler_curvature
// zyx euler angles from a q1.14 quaternion through cordic atan2 cell chains,
// pitch via square root cells, curvature via restoring divide cells
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_euler_curvature #(
    parameter int CORDIC_STAGES = qec_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] speed,
    input  logic signed [15:0] turn_rate,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] roll_angle,
    output logic signed [15:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic signed [23:0] curvature
);
    import qec_pkg::*;

    localparam int LAT = 34 + CORDIC_STAGES;
    localparam int RY_DLY = SQ_STEPS + 2;
    localparam int DV_DLY = CORDIC_STAGES + 3;

    logic en;
    logic [LAT-1:0] vld_reg;

    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg, xy_reg, zz_reg;
    logic signed [31:0] wy_reg, zx_reg;
    logic signed [15:0] spd_reg, rate_reg;

    logic signed [33:0] num_r, den_r, num_y, den_y, s_raw;
    logic signed [SW-1:0] s_next, s_reg;
    logic signed [27:0] dvd_s;
    cvec_t roll_pre_reg, yaw_pre_reg, pitch_pre_reg;
    div_t  div_pre_reg, div_next;
    sqrt_t sq_pre_reg;
    logic signed [59:0] s_sq;

    cvec_t roll_v  [CORDIC_STAGES+1];
    cvec_t yaw_v   [CORDIC_STAGES+1];
    cvec_t pitch_v [CORDIC_STAGES+1];
    sqrt_t sq_v    [SQ_STEPS+1];
    div_t  dv_v    [DIV_STEPS+1];

    logic signed [AW-1:0] roll_a, yaw_a, roll_d, yaw_d;
    logic signed [DW:0]   q_s;
    logic signed [CW-1:0] kap, kap_d;

    logic signed [AW-1:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [CW-1:0] curv_reg;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    assign out_valid = vld_reg[LAT-1];

    // products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg   <= quat_w * quat_x;
            yz_reg   <= quat_y * quat_z;
            xx_reg   <= quat_x * quat_x;
            yy_reg   <= quat_y * quat_y;
            wz_reg   <= quat_w * quat_z;
            xy_reg   <= quat_x * quat_y;
            zz_reg   <= quat_z * quat_z;
            wy_reg   <= quat_w * quat_y;
            zx_reg   <= quat_z * quat_x;
            spd_reg  <= speed;
            rate_reg <= turn_rate;
        end
    end

    // sums, pitch clamp, divide setup
    always_comb
    begin
        num_r = (34'(wx_reg) + 34'(yz_reg)) <<< 1;
        den_r = 34'sd268435456 - ((34'(xx_reg) + 34'(yy_reg)) <<< 1);
        num_y = (34'(wz_reg) + 34'(xy_reg)) <<< 1;
        den_y = 34'sd268435456 - ((34'(yy_reg) + 34'(zz_reg)) <<< 1);
        s_raw = (34'(wy_reg) - 34'(zx_reg)) <<< 1;
        if (s_raw > 34'sd268435456)
            s_next = 30'sd268435456;
        else if (s_raw < -34'sd268435456)
            s_next = -30'sd268435456;
        else
            s_next = SW'(s_raw);

        dvd_s        = 28'(rate_reg) <<< 12;
        div_next.dvd = dvd_s[27] ? DW'(-dvd_s) : DW'(dvd_s);
        div_next.dsr = spd_reg[15] ? DSW'(-spd_reg) : DSW'(spd_reg);
        div_next.rem = '0;
        div_next.quo = '0;
        div_next.neg = rate_reg[15] ^ spd_reg[15];
        div_next.zf  = (spd_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_pre_reg <= cordic_pre(VW'(num_r), VW'(den_r));
            yaw_pre_reg  <= cordic_pre(VW'(num_y), VW'(den_y));
            s_reg        <= s_next;
            div_pre_reg  <= div_next;
        end
    end

    // 1 - s*s for the cosine
    assign s_sq = s_reg * s_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_pre_reg.n    <= NW'((60'sd1 <<< 56) - s_sq);
            sq_pre_reg.rem  <= '0;
            sq_pre_reg.root <= '0;
            sq_pre_reg.s    <= s_reg;
        end
    end

    assign sq_v[0] = sq_pre_reg;

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        qec_sqrt_cell u_sqrt (
            .clk  (clk),
            .en   (en),
            .vin  (sq_v[k]),
            .vout (sq_v[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pitch_pre_reg <= cordic_pre(VW'(sq_v[SQ_STEPS].s), VW'(sq_v[SQ_STEPS].root));
    end

    assign roll_v[0]  = roll_pre_reg;
    assign yaw_v[0]   = yaw_pre_reg;
    assign pitch_v[0] = pitch_pre_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        qec_cordic_cell #(.IDX(i)) u_roll (
            .clk  (clk),
            .en   (en),
            .vin  (roll_v[i]),
            .vout (roll_v[i+1])
        );
        qec_cordic_cell #(.IDX(i)) u_yaw (
            .clk  (clk),
            .en   (en),
            .vin  (yaw_v[i]),
            .vout (yaw_v[i+1])
        );
        qec_cordic_cell #(.IDX(i)) u_pitch (
            .clk  (clk),
            .en   (en),
            .vin  (pitch_v[i]),
            .vout (pitch_v[i+1])
        );
    end

    assign dv_v[0] = div_pre_reg;

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        qec_div_cell u_div (
            .clk  (clk),
            .en   (en),
            .vin  (dv_v[j]),
            .vout (dv_v[j+1])
        );
    end

    // sign and saturate the quotient, zero when speed is zero
    always_comb
    begin
        q_s = dv_v[DIV_STEPS].neg ? -$signed({1'b0, dv_v[DIV_STEPS].quo})
                                  : $signed({1'b0, dv_v[DIV_STEPS].quo});
        if (dv_v[DIV_STEPS].zf)
            kap = '0;
        else if (q_s > (DW+1)'(8388607))
            kap = 24'sd8388607;
        else if (q_s < -(DW+1)'(8388608))
            kap = -24'sd8388608;
        else
            kap = CW'(q_s);
    end

    assign roll_a = angle_out(roll_v[CORDIC_STAGES].z, roll_v[CORDIC_STAGES].zf);
    assign yaw_a  = angle_out(yaw_v[CORDIC_STAGES].z, yaw_v[CORDIC_STAGES].zf);

    qec_delay #(.WIDTH(AW), .DEPTH(RY_DLY)) u_roll_dly (
        .clk  (clk),
        .en   (en),
        .din  (roll_a),
        .dout (roll_d)
    );

    qec_delay #(.WIDTH(AW), .DEPTH(RY_DLY)) u_yaw_dly (
        .clk  (clk),
        .en   (en),
        .din  (yaw_a),
        .dout (yaw_d)
    );

    qec_delay #(.WIDTH(CW), .DEPTH(DV_DLY)) u_curv_dly (
        .clk  (clk),
        .en   (en),
        .din  (kap),
        .dout (kap_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_d;
            yaw_reg   <= yaw_d;
            pitch_reg <= angle_out(pitch_v[CORDIC_STAGES].z, pitch_v[CORDIC_STAGES].zf);
            curv_reg  <= kap_d;
        end
    end

    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;
    assign curvature   = curv_reg;

    `QEC_ASSERT(a_pitch_range, out_valid |-> (pitch_angle <= 16'sd16384) && (pitch_angle >= -16'sd16384), "pitch outside half circle")
    `QEC_ASSERT_NEXT(a_hold_on_stall, in_stall, $stable(vld_reg), "pipeline moved while stalled")
    `QEC_ASSERT(a_stall_cause, in_stall |-> out_valid, "input stalled without a pending result")

endmodule

// File: hw/rtl/qec_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qec_cordic_cell
// one vectoring cordic micro-rotation, registered
// ----------------------------------------------------------------------------
module qec_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic           clk,
    input  logic           en,
    input  qec_pkg::cvec_t vin,
    output qec_pkg::cvec_t vout
);
    import qec_pkg::*;

    cvec_t                vec_reg;
    cvec_t                vec_next;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;

    always_comb
    begin
        dx       = $signed(vin.y) >>> IDX;
        dy       = $signed(vin.x) >>> IDX;
        vec_next = vin;
        if ($signed(vin.y) > 0)
        begin
            vec_next.x = vin.x + dx;
            vec_next.y = vin.y - dy;
            vec_next.z = vin.z + atan_tab(IDX);
        end
        else
        begin
            vec_next.x = vin.x - dx;
            vec_next.y = vin.y + dy;
            vec_next.z = vin.z - atan_tab(IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vec_reg <= vec_next;
    end

    assign vout = vec_reg;

endmodule

// File: hw/rtl/qec_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qec_sqrt_cell
// one digit step of a restoring integer square root, registered
// ----------------------------------------------------------------------------
module qec_sqrt_cell (
    input  logic           clk,
    input  logic           en,
    input  qec_pkg::sqrt_t vin,
    output qec_pkg::sqrt_t vout
);
    import qec_pkg::*;

    sqrt_t         sq_reg;
    sqrt_t         sq_next;
    logic [RW+1:0] rsh;
    logic [RW+1:0] trial;

    always_comb
    begin
        rsh     = {vin.rem, vin.n[NW-1:NW-2]};
        trial   = (RW+2)'({vin.root, 2'b01});
        sq_next = vin;
        sq_next.n = {vin.n[NW-3:0], 2'b00};
        if (rsh >= trial)
        begin
            sq_next.rem  = RW'(rsh - trial);
            sq_next.root = {vin.root[RTW-2:0], 1'b1};
        end
        else
        begin
            sq_next.rem  = RW'(rsh);
            sq_next.root = {vin.root[RTW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sq_reg <= sq_next;
    end

    assign vout = sq_reg;

endmodule

// File: hw/rtl/qec_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qec_div_cell
// one quotient bit of a restoring unsigned divide, registered
// ----------------------------------------------------------------------------
module qec_div_cell (
    input  logic          clk,
    input  logic          en,
    input  qec_pkg::div_t vin,
    output qec_pkg::div_t vout
);
    import qec_pkg::*;

    div_t         dv_reg;
    div_t         dv_next;
    logic [DSW:0] r2;

    always_comb
    begin
        r2      = {vin.rem, vin.dvd[DW-1]};
        dv_next = vin;
        dv_next.dvd = {vin.dvd[DW-2:0], 1'b0};
        if (r2 >= {1'b0, vin.dsr})
        begin
            dv_next.rem = DSW'(r2 - {1'b0, vin.dsr});
            dv_next.quo = {vin.quo[DW-2:0], 1'b1};
        end
        else
        begin
            dv_next.rem = DSW'(r2);
            dv_next.quo = {vin.quo[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dv_reg <= dv_next;
    end

    assign vout = dv_reg;

endmodule

// File: hw/rtl/qec_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qec_delay
// enabled shift line that aligns one lane with the longest lane
// ----------------------------------------------------------------------------
module qec_delay #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);
    import qec_pkg::*;

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
                pipe_reg[k] <= pipe_reg[k-1];
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule
